FILE: rtl/stq_pkg.sv
// Shared constants and types for the sorted timer queue.
// No dependencies; compile before every other file.
`default_nettype none
package stq_pkg;

    localparam int NUM_TIMERS_DEF = 16;
    localparam int CMD_W          = 3;
    localparam int TIME_W         = 64;
    localparam int ID_W           = 4;
    localparam int STATUS_W       = 2;

    localparam logic [TIME_W-1:0] HOUR_MS = TIME_W'(64'd3600000);

    typedef enum logic [CMD_W-1:0] {
        CMD_ADD       = 3'd0,
        CMD_CANCEL    = 3'd1,
        CMD_REFRESH   = 3'd2,
        CMD_RESET     = 3'd3,
        CMD_NEXT_WAIT = 3'd4,
        CMD_COLLECT   = 3'd5
    } t_cmd;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK         = 2'd0,
        ST_NOT_ACTIVE = 2'd1,
        ST_FULL       = 2'd2,
        ST_NOTHING    = 2'd3
    } t_status;

    typedef enum logic {
        ALU_ADD = 1'b0,
        ALU_SUB = 1'b1
    } t_alu_op;

endpackage
`default_nettype wire

FILE: rtl/stq_if.sv
// Valid/ready channels for command items and result items.
// Depends on stq_pkg.
`default_nettype none
interface stq_in_if;
    import stq_pkg::*;
    logic                valid;
    logic                ready;
    logic [CMD_W-1:0]    command;
    logic [TIME_W-1:0]   now_ms;
    logic [ID_W-1:0]     timer_id;
    logic [TIME_W-1:0]   period_ms;
    logic                repeat_req;
    logic                restart_now;
    modport source (output valid, command, now_ms, timer_id, period_ms, repeat_req,
                    restart_now, input ready);
    modport sink   (input valid, command, now_ms, timer_id, period_ms, repeat_req,
                    restart_now, output ready);
endinterface

interface stq_out_if;
    import stq_pkg::*;
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [ID_W-1:0]     handle;
    logic [TIME_W-1:0]   wait_ms;
    logic                front_notify;
    logic                last;
    logic                pending;
    modport source (output valid, status, handle, wait_ms, front_notify, last, pending,
                    input ready);
    modport sink   (input valid, status, handle, wait_ms, front_notify, last, pending,
                    output ready);
endinterface
`default_nettype wire

FILE: rtl/sorted_timer_queue_top.sv
// Sorted timer queue: top level with sequencer, slot memories and output register.
// Depends on stq_pkg, stq_if (stq_in_if, stq_out_if) and stq_alu.
`default_nettype none
// One command item is taken at a time; in_ready is high only while the block is idle.
// Cancel, refresh, unknown commands and the short cases of reset answer straight
// from the calc state. Add, next-wait, the full reset and the first pass of
// collect-expired walk the deadline memory one slot per cycle through the shared
// compare path before the decide state answers. The block returns to idle after
// the last output transfer and only then takes the next input transfer.
// Each expired timer that collect reports costs one more walk of the slot
// memories, since the next timer in deadline order is found by a fresh scan.
// Results leave through a registered output; the block waits for each transfer
// before going on. No clearing pass runs after reset: only the active marks and
// control state are cleared. Scans use deadlines of active slots only, but a
// reset command compares against the period memory of any slot it names.
module sorted_timer_queue_top #(
    parameter int NUM_TIMERS = stq_pkg::NUM_TIMERS_DEF
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    stq_in_if.sink    i_in,
    stq_out_if.source o_out
);
    import stq_pkg::*;

    localparam int IW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
    localparam int CW = IW + 1;
    localparam logic [CW-1:0] CNT_END = CW'(NUM_TIMERS);

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_CALC   = 5'b00010,
        S_SCAN   = 5'b00100,
        S_DECIDE = 5'b01000,
        S_OUT    = 5'b10000
    } t_state;

    // Slot memories: one shared read address, one write address for each memory.
    logic [TIME_W-1:0] r_dl_mem  [NUM_TIMERS];
    logic [TIME_W-1:0] r_per_mem [NUM_TIMERS];
    logic [TIME_W-1:0] r_dl_q, r_per_q;
    logic [IW-1:0]     w_raddr;
    logic              w_dl_we, w_per_we;
    logic [IW-1:0]     w_dl_wa, w_per_wa;
    logic [TIME_W-1:0] w_dl_wd, w_per_wd;

    // Control state.
    t_state              r_state, n_state;
    logic [NUM_TIMERS-1:0] r_active, n_active;
    logic [NUM_TIMERS-1:0] r_mask, n_mask;
    logic                r_notice, n_notice;
    logic [TIME_W-1:0]   r_prev, n_prev;
    logic                r_phase, n_phase;
    logic [CW-1:0]       r_cnt, n_cnt;
    logic                r_q_vld, n_q_vld;
    logic                r_out_vld, n_out_vld;

    // Payload state.
    logic [NUM_TIMERS-1:0] r_rep, n_rep;
    t_cmd                r_cmd, n_cmd;
    logic [TIME_W-1:0]   r_now, n_now;
    logic [ID_W-1:0]     r_id, n_id;
    logic [TIME_W-1:0]   r_per, n_per;
    logic                r_rep_req, n_rep_req;
    logic                r_fnow, n_fnow;
    logic [TIME_W-1:0]   r_tmp, n_tmp;
    logic                r_roll, n_roll;
    logic [IW-1:0]       r_q_idx, n_q_idx;
    logic                r_best_vld, n_best_vld;
    logic [IW-1:0]       r_best_idx, n_best_idx;
    logic [TIME_W-1:0]   r_best_dl, n_best_dl;
    logic [TIME_W-1:0]   r_best_per, n_best_per;
    logic                r_free_vld, n_free_vld;
    logic [IW-1:0]       r_free_idx, n_free_idx;
    logic                r_any, n_any;
    t_status             r_o_status, n_o_status;
    logic [ID_W-1:0]     r_o_handle, n_o_handle;
    logic [TIME_W-1:0]   r_o_wait, n_o_wait;
    logic                r_o_fn, n_o_fn;
    logic                r_o_last, n_o_last;
    logic                r_o_pend, n_o_pend;

    // Shared adder.
    logic [TIME_W-1:0] w_alu_a, w_alu_b, w_alu_y;
    t_alu_op           w_alu_op;

    stq_alu u_alu (
        .i_a  (w_alu_a),
        .i_b  (w_alu_b),
        .i_op (w_alu_op),
        .o_y  (w_alu_y)
    );

    logic          w_in_fire, w_out_fire;
    logic [IW-1:0] w_sid;
    logic          w_id_ok;
    logic          w_in_set;
    logic          w_early;

    assign w_in_fire  = i_in.valid && i_in.ready;
    assign w_out_fire = r_out_vld && o_out.ready;
    assign w_sid      = IW'(r_id);
    assign w_id_ok    = (32'(r_id) < NUM_TIMERS);

    assign i_in.ready         = (r_state == S_IDLE);
    assign o_out.valid        = r_out_vld;
    assign o_out.status       = r_o_status;
    assign o_out.handle       = r_o_handle;
    assign o_out.wait_ms      = r_o_wait;
    assign o_out.front_notify = r_o_fn;
    assign o_out.last         = r_o_last;
    assign o_out.pending      = r_o_pend;

    // Read address: the scan counter while scanning, the slot named on the input otherwise.
    always_comb begin
        if (r_state == S_SCAN) begin
            w_raddr = r_cnt[IW-1:0];
        end else begin
            w_raddr = IW'(i_in.timer_id);
        end
    end

    // Slot under scan belongs to the set whose earliest member is searched.
    always_comb begin
        if (r_phase) begin
            w_in_set = r_mask[r_q_idx];
        end else begin
            w_in_set = r_active[r_q_idx] && !(r_cmd == CMD_RESET && r_q_idx == w_sid);
        end
    end

    always_comb begin
        n_state    = r_state;
        n_active   = r_active;
        n_mask     = r_mask;
        n_notice   = r_notice;
        n_prev     = r_prev;
        n_phase    = r_phase;
        n_cnt      = r_cnt;
        n_q_vld    = 1'b0;
        n_out_vld  = r_out_vld;
        n_rep      = r_rep;
        n_cmd      = r_cmd;
        n_now      = r_now;
        n_id       = r_id;
        n_per      = r_per;
        n_rep_req  = r_rep_req;
        n_fnow     = r_fnow;
        n_tmp      = r_tmp;
        n_roll     = r_roll;
        n_q_idx    = r_q_idx;
        n_best_vld = r_best_vld;
        n_best_idx = r_best_idx;
        n_best_dl  = r_best_dl;
        n_best_per = r_best_per;
        n_free_vld = r_free_vld;
        n_free_idx = r_free_idx;
        n_any      = r_any;
        n_o_status = r_o_status;
        n_o_handle = r_o_handle;
        n_o_wait   = r_o_wait;
        n_o_fn     = r_o_fn;
        n_o_last   = r_o_last;
        n_o_pend   = r_o_pend;
        w_alu_a    = r_now;
        w_alu_b    = r_per;
        w_alu_op   = ALU_ADD;
        w_dl_we    = 1'b0;
        w_dl_wa    = w_sid;
        w_dl_wd    = w_alu_y;
        w_per_we   = 1'b0;
        w_per_wa   = w_sid;
        w_per_wd   = r_per;
        w_early    = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (w_in_fire) begin
                    n_cmd     = t_cmd'(i_in.command);
                    n_now     = i_in.now_ms;
                    n_id      = i_in.timer_id;
                    n_per     = i_in.period_ms;
                    n_rep_req = i_in.repeat_req;
                    n_fnow    = i_in.restart_now;
                    n_tmp     = i_in.now_ms;
                    n_phase   = 1'b0;
                    n_state   = S_CALC;
                end
            end

            S_CALC: begin
                // Defaults for a single answer; scanning commands override below.
                n_o_status = ST_OK;
                n_o_handle = r_id;
                n_o_wait   = '0;
                n_o_fn     = 1'b0;
                n_o_last   = 1'b1;
                n_out_vld  = 1'b1;
                n_state    = S_OUT;
                unique case (r_cmd)
                    CMD_ADD, CMD_NEXT_WAIT: begin
                        n_out_vld = 1'b0;
                    end
                    CMD_CANCEL: begin
                        if (w_id_ok && r_active[w_sid]) begin
                            n_active[w_sid] = 1'b0;
                        end else begin
                            n_o_status = ST_NOT_ACTIVE;
                        end
                    end
                    CMD_REFRESH: begin
                        w_alu_a = r_now;
                        w_alu_b = r_per_q;
                        if (w_id_ok && r_active[w_sid]) begin
                            w_dl_we = 1'b1;
                        end else begin
                            n_o_status = ST_NOT_ACTIVE;
                        end
                    end
                    CMD_RESET: begin
                        w_alu_a  = r_dl_q;
                        w_alu_b  = r_per_q;
                        w_alu_op = ALU_SUB;
                        priority if (!w_id_ok) begin
                            n_o_status = ST_NOT_ACTIVE;
                        end else if (r_per == r_per_q && !r_fnow) begin
                            n_o_status = ST_OK;
                        end else if (!r_active[w_sid]) begin
                            n_o_status = ST_NOT_ACTIVE;
                        end else begin
                            // Start from now, or from the old start time.
                            n_tmp     = r_fnow ? r_now : w_alu_y;
                            n_out_vld = 1'b0;
                        end
                    end
                    CMD_COLLECT: begin
                        // Detect a step back of more than one hour.
                        w_alu_a   = r_prev;
                        w_alu_b   = HOUR_MS;
                        w_alu_op  = ALU_SUB;
                        n_roll    = (r_now < r_prev) && (r_now < w_alu_y);
                        n_out_vld = 1'b0;
                    end
                    default: begin
                        n_o_handle = '0;
                    end
                endcase
                if (!n_out_vld) begin
                    n_cnt      = '0;
                    n_best_vld = 1'b0;
                    n_free_vld = 1'b0;
                    n_any      = 1'b0;
                    n_state    = S_SCAN;
                end
                n_o_pend = |n_active;
            end

            S_SCAN: begin
                if (r_q_vld) begin
                    if (w_in_set && (!r_best_vld || r_dl_q < r_best_dl)) begin
                        n_best_vld = 1'b1;
                        n_best_idx = r_q_idx;
                        n_best_dl  = r_dl_q;
                        n_best_per = r_per_q;
                    end
                    if (!r_active[r_q_idx] && !r_free_vld) begin
                        n_free_vld = 1'b1;
                        n_free_idx = r_q_idx;
                    end
                    if (r_cmd == CMD_COLLECT && !r_phase) begin
                        n_mask[r_q_idx] = r_active[r_q_idx] && (r_roll || r_dl_q <= r_now);
                        if (r_active[r_q_idx] && (r_roll || r_dl_q <= r_now)) begin
                            n_any = 1'b1;
                        end
                    end
                end
                if (r_cnt != CNT_END) begin
                    n_cnt   = r_cnt + CW'(1);
                    n_q_vld = 1'b1;
                    n_q_idx = r_cnt[IW-1:0];
                end else if (!r_q_vld) begin
                    n_state = S_DECIDE;
                end
            end

            S_DECIDE: begin
                n_o_status = ST_OK;
                n_o_handle = r_id;
                n_o_wait   = '0;
                n_o_fn     = 1'b0;
                n_o_last   = 1'b1;
                n_out_vld  = 1'b1;
                n_state    = S_OUT;
                unique case (r_cmd)
                    CMD_ADD: begin
                        w_alu_a = r_tmp;
                        w_alu_b = r_per;
                        if (!r_free_vld) begin
                            n_o_status = ST_FULL;
                            n_o_handle = '0;
                        end else begin
                            w_dl_we   = 1'b1;
                            w_dl_wa   = r_free_idx;
                            w_per_we  = 1'b1;
                            w_per_wa  = r_free_idx;
                            n_rep[r_free_idx]    = r_rep_req;
                            n_active[r_free_idx] = 1'b1;
                            w_early = !r_best_vld || (w_alu_y < r_best_dl) ||
                                      (w_alu_y == r_best_dl && r_free_idx < r_best_idx);
                            n_o_fn     = w_early && !r_notice;
                            n_notice   = r_notice || w_early;
                            n_o_handle = ID_W'(r_free_idx);
                        end
                    end
                    CMD_RESET: begin
                        w_alu_a  = r_tmp;
                        w_alu_b  = r_per;
                        w_dl_we  = 1'b1;
                        w_per_we = 1'b1;
                        w_early  = !r_best_vld || (w_alu_y < r_best_dl) ||
                                   (w_alu_y == r_best_dl && w_sid < r_best_idx);
                        n_o_fn   = w_early && !r_notice;
                        n_notice = r_notice || w_early;
                    end
                    CMD_NEXT_WAIT: begin
                        w_alu_a    = r_best_dl;
                        w_alu_b    = r_now;
                        w_alu_op   = ALU_SUB;
                        n_notice   = 1'b0;
                        n_o_handle = '0;
                        priority if (!r_best_vld) begin
                            n_o_wait = '1;
                        end else if (r_now >= r_best_dl) begin
                            n_o_wait = '0;
                        end else begin
                            n_o_wait = w_alu_y;
                        end
                    end
                    CMD_COLLECT: begin
                        w_alu_a    = r_now;
                        w_alu_b    = r_best_per;
                        n_o_handle = '0;
                        if (!r_phase) begin
                            if (!r_best_vld) begin
                                n_o_status = ST_NOTHING;
                            end else begin
                                n_prev = r_now;
                                if (!r_any) begin
                                    n_o_status = ST_NOTHING;
                                end else begin
                                    // Walk the expired set in deadline order.
                                    n_phase    = 1'b1;
                                    n_out_vld  = 1'b0;
                                    n_cnt      = '0;
                                    n_best_vld = 1'b0;
                                    n_free_vld = 1'b0;
                                    n_state    = S_SCAN;
                                end
                            end
                        end else begin
                            // Emit the earliest expired slot; rearm or free it.
                            n_o_handle = ID_W'(r_best_idx);
                            n_mask[r_best_idx] = 1'b0;
                            n_o_last = ~|n_mask;
                            if (r_rep[r_best_idx]) begin
                                w_dl_we = 1'b1;
                                w_dl_wa = r_best_idx;
                            end else begin
                                n_active[r_best_idx] = 1'b0;
                            end
                        end
                    end
                    default: begin
                        n_o_handle = '0;
                    end
                endcase
                if (r_cmd == CMD_COLLECT && r_phase) begin
                    n_o_pend = |(r_active & ~(r_mask & ~r_rep));
                end else begin
                    n_o_pend = |n_active;
                end
            end

            S_OUT: begin
                if (w_out_fire) begin
                    n_out_vld = 1'b0;
                    if (r_phase && !r_o_last) begin
                        n_cnt      = '0;
                        n_best_vld = 1'b0;
                        n_free_vld = 1'b0;
                        n_state    = S_SCAN;
                    end else begin
                        n_phase = 1'b0;
                        n_state = S_IDLE;
                    end
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Slot memories with registered reads.
    always_ff @(posedge i_clk) begin
        if (w_dl_we) begin
            r_dl_mem[w_dl_wa] <= w_dl_wd;
        end
        if (w_per_we) begin
            r_per_mem[w_per_wa] <= w_per_wd;
        end
        r_dl_q  <= r_dl_mem[w_raddr];
        r_per_q <= r_per_mem[w_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_active  <= '0;
            r_mask    <= '0;
            r_notice  <= 1'b0;
            r_prev    <= '0;
            r_phase   <= 1'b0;
            r_cnt     <= '0;
            r_q_vld   <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_active  <= n_active;
            r_mask    <= n_mask;
            r_notice  <= n_notice;
            r_prev    <= n_prev;
            r_phase   <= n_phase;
            r_cnt     <= n_cnt;
            r_q_vld   <= n_q_vld;
            r_out_vld <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rep      <= n_rep;
        r_cmd      <= n_cmd;
        r_now      <= n_now;
        r_id       <= n_id;
        r_per      <= n_per;
        r_rep_req  <= n_rep_req;
        r_fnow     <= n_fnow;
        r_tmp      <= n_tmp;
        r_roll     <= n_roll;
        r_q_idx    <= n_q_idx;
        r_best_vld <= n_best_vld;
        r_best_idx <= n_best_idx;
        r_best_dl  <= n_best_dl;
        r_best_per <= n_best_per;
        r_free_vld <= n_free_vld;
        r_free_idx <= n_free_idx;
        r_any      <= n_any;
        r_o_status <= n_o_status;
        r_o_handle <= n_o_handle;
        r_o_wait   <= n_o_wait;
        r_o_fn     <= n_o_fn;
        r_o_last   <= n_o_last;
        r_o_pend   <= n_o_pend;
    end

endmodule
`default_nettype wire

FILE: rtl/stq_alu.sv
// Shared 64-bit add/subtract unit of the timer queue sequencer.
// Depends on stq_pkg.
`default_nettype none
module stq_alu (
    input  wire logic [stq_pkg::TIME_W-1:0] i_a,
    input  wire logic [stq_pkg::TIME_W-1:0] i_b,
    input  wire stq_pkg::t_alu_op           i_op,
    output logic      [stq_pkg::TIME_W-1:0] o_y
);
    import stq_pkg::*;

    always_comb begin
        unique case (i_op)
            ALU_ADD: o_y = i_a + i_b;
            ALU_SUB: o_y = i_a - i_b;
            default: o_y = i_a + i_b;
        endcase
    end

endmodule
`default_nettype wire

FILE: verif/sorted_timer_queue_top_tb.sv
// Self-checking testbench for sorted_timer_queue_top: drives random and directed
// timer commands, predicts every result item and compares them field by field.
// Depends on stq_pkg, stq_if and the RTL of sorted_timer_queue_top.
`timescale 1ns / 1ps
module sorted_timer_queue_top_tb;
    import stq_pkg::*;

    localparam int NT = NUM_TIMERS_DEF;
    // Cycles without any transfer before the run is declared hung.
    localparam int HANG_LIMIT = 20000;

    typedef struct {
        t_cmd         command;
        logic [63:0]  now_ms;
        logic [3:0]   timer_id;
        logic [63:0]  period_ms;
        logic         repeat_req;
        logic         restart_now;
    } t_timer_cmd;

    typedef struct {
        t_status      status;
        logic [3:0]   handle;
        logic [63:0]  wait_ms;
        logic         front_notify;
        logic         last;
        logic         pending;
    } t_timer_res;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    stq_in_if  cmd_ch();
    stq_out_if res_ch();

    sorted_timer_queue_top uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (cmd_ch.sink),
        .o_out   (res_ch.source)
    );

    always #5 i_clk = ~i_clk;

    // Shadow copy of the timer table.
    logic        sh_active   [NT];
    logic        sh_repeat   [NT];
    logic [63:0] sh_period   [NT];
    logic [63:0] sh_deadline [NT];
    logic        sh_notice;
    logic [63:0] sh_prev_time;

    t_timer_cmd cmd_queue [$];
    t_timer_res expected_results [$];

    int     send_idle_pct = 21;
    int     recv_idle_pct = 58;
    int     mismatches = 0;
    int     hang_count = 0;
    logic [63:0] clock_ms = 64'd0;

    // Earliest active slot among mask; ties go to the lower index.
    function automatic int earliest_slot(logic m [NT]);
        int best;
        best = -1;
        for (int i = 0; i < NT; i++)
            if (m[i] && (best < 0 || sh_deadline[i] < sh_deadline[best]))
                best = i;
        return best;
    endfunction

    function automatic logic front_check(int s);
        if (earliest_slot(sh_active) == s && !sh_notice) begin
            sh_notice = 1'b1;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic t_timer_res mk(t_status st, logic [3:0] h, logic [63:0] w,
                                      logic fn, logic lst);
        t_timer_res r;
        r.status = st;
        r.handle = h;
        r.wait_ms = w;
        r.front_notify = fn;
        r.last = lst;
        r.pending = 1'b0;
        return r;
    endfunction

    // Advance the shadow table by one command and queue the results it causes.
    task automatic predict_timer_step(t_timer_cmd c);
        t_timer_res outs [$];
        logic       mask [NT];
        logic       roll;
        logic       any;
        logic [63:0] start;
        logic [63:0] w;
        int         f;
        int         e;
        int         m;
        int         s;
        s = c.timer_id;
        case (c.command)
            CMD_ADD: begin
                f = -1;
                for (int i = NT - 1; i >= 0; i--)
                    if (!sh_active[i]) f = i;
                if (f < 0) begin
                    outs.insert(outs.size(), mk(ST_FULL, 4'd0, 64'd0, 1'b0, 1'b1));
                end else begin
                    sh_active[f] = 1'b1;
                    sh_repeat[f] = c.repeat_req;
                    sh_period[f] = c.period_ms;
                    sh_deadline[f] = c.now_ms + c.period_ms;
                    outs.insert(outs.size(), mk(ST_OK, 4'(f), 64'd0, front_check(f), 1'b1));
                end
            end
            CMD_CANCEL: begin
                if (sh_active[s]) begin
                    sh_active[s] = 1'b0;
                    outs.insert(outs.size(), mk(ST_OK, c.timer_id, 64'd0, 1'b0, 1'b1));
                end else begin
                    outs.insert(outs.size(),
                                mk(ST_NOT_ACTIVE, c.timer_id, 64'd0, 1'b0, 1'b1));
                end
            end
            CMD_REFRESH: begin
                if (sh_active[s]) begin
                    sh_deadline[s] = c.now_ms + sh_period[s];
                    outs.insert(outs.size(), mk(ST_OK, c.timer_id, 64'd0, 1'b0, 1'b1));
                end else begin
                    outs.insert(outs.size(),
                                mk(ST_NOT_ACTIVE, c.timer_id, 64'd0, 1'b0, 1'b1));
                end
            end
            CMD_RESET: begin
                if (c.period_ms == sh_period[s] && !c.restart_now) begin
                    outs.insert(outs.size(), mk(ST_OK, c.timer_id, 64'd0, 1'b0, 1'b1));
                end else if (!sh_active[s]) begin
                    outs.insert(outs.size(),
                                mk(ST_NOT_ACTIVE, c.timer_id, 64'd0, 1'b0, 1'b1));
                end else begin
                    start = c.restart_now ? c.now_ms : sh_deadline[s] - sh_period[s];
                    sh_period[s] = c.period_ms;
                    sh_deadline[s] = start + c.period_ms;
                    outs.insert(outs.size(),
                                mk(ST_OK, c.timer_id, 64'd0, front_check(s), 1'b1));
                end
            end
            CMD_NEXT_WAIT: begin
                e = earliest_slot(sh_active);
                sh_notice = 1'b0;
                if (e < 0) w = '1;
                else if (c.now_ms >= sh_deadline[e]) w = 64'd0;
                else w = sh_deadline[e] - c.now_ms;
                outs.insert(outs.size(), mk(ST_OK, 4'd0, w, 1'b0, 1'b1));
            end
            CMD_COLLECT: begin
                e = earliest_slot(sh_active);
                if (e < 0) begin
                    outs.insert(outs.size(), mk(ST_NOTHING, 4'd0, 64'd0, 1'b0, 1'b1));
                end else begin
                    roll = c.now_ms < sh_prev_time && c.now_ms < sh_prev_time - HOUR_MS;
                    sh_prev_time = c.now_ms;
                    if (!roll && sh_deadline[e] > c.now_ms) begin
                        outs.insert(outs.size(), mk(ST_NOTHING, 4'd0, 64'd0, 1'b0, 1'b1));
                    end else begin
                        // Order by the old deadlines, then rearm or free.
                        for (int i = 0; i < NT; i++)
                            mask[i] = sh_active[i] && (roll || sh_deadline[i] <= c.now_ms);
                        m = earliest_slot(mask);
                        while (m >= 0) begin
                            mask[m] = 1'b0;
                            outs.insert(outs.size(), mk(ST_OK, 4'(m), 64'd0, 1'b0, 1'b0));
                            m = earliest_slot(mask);
                        end
                        foreach (outs[k]) begin
                            if (sh_repeat[outs[k].handle])
                                sh_deadline[outs[k].handle] = c.now_ms
                                    + sh_period[outs[k].handle];
                            else
                                sh_active[outs[k].handle] = 1'b0;
                        end
                        outs[outs.size() - 1].last = 1'b1;
                    end
                end
            end
            default: outs.insert(outs.size(), mk(ST_OK, 4'd0, 64'd0, 1'b0, 1'b1));
        endcase
        any = 1'b0;
        for (int i = 0; i < NT; i++) any |= sh_active[i];
        foreach (outs[k]) begin
            outs[k].pending = any;
            expected_results.insert(expected_results.size(), outs[k]);
        end
    endtask

    // Driver: hold the current item until its transfer, then advance.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cmd_ch.valid <= 1'b0;
        end else if (!cmd_ch.valid || cmd_ch.ready) begin
            if (cmd_ch.valid) predict_timer_step(cmd_queue.pop_front());
            if (cmd_queue.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                cmd_ch.valid       <= 1'b1;
                cmd_ch.command     <= cmd_queue[0].command;
                cmd_ch.now_ms      <= cmd_queue[0].now_ms;
                cmd_ch.timer_id    <= cmd_queue[0].timer_id;
                cmd_ch.period_ms   <= cmd_queue[0].period_ms;
                cmd_ch.repeat_req  <= cmd_queue[0].repeat_req;
                cmd_ch.restart_now <= cmd_queue[0].restart_now;
            end else begin
                cmd_ch.valid <= 1'b0;
            end
        end
    end

    // Monitor: compare each result transfer with the oldest expectation.
    always @(posedge i_clk) begin
        t_timer_res exp_r;
        if (!i_rst_n) begin
            res_ch.ready <= 1'b0;
        end else begin
            if ((cmd_ch.valid && cmd_ch.ready) || (res_ch.valid && res_ch.ready))
                hang_count <= 0;
            else
                hang_count <= hang_count + 1;
            if (res_ch.valid && res_ch.ready) begin
                // A result with nothing expected on a command transfer edge came before its command.
                if (expected_results.size() == 0 && cmd_ch.valid && cmd_ch.ready) begin
                    mismatches <= mismatches + 1;
                    if (mismatches < 10)
                        $display("result before its command transfer at %0t", $time);
                end else if (expected_results.size() == 0) begin
                    mismatches <= mismatches + 1;
                    if (mismatches < 10)
                        $display("unexpected result: handle %0d status %0d",
                                 res_ch.handle, res_ch.status);
                end else begin
                    exp_r = expected_results.pop_front();
                    if (res_ch.status !== exp_r.status || res_ch.handle !== exp_r.handle
                        || res_ch.wait_ms !== exp_r.wait_ms
                        || res_ch.front_notify !== exp_r.front_notify
                        || res_ch.last !== exp_r.last
                        || res_ch.pending !== exp_r.pending) begin
                        mismatches <= mismatches + 1;
                        if (mismatches < 10)
                            $display(
                                "mismatch exp %0d %0d %0h %0b %0b %0b got %0d %0d %0h %0b %0b %0b",
                                exp_r.status, exp_r.handle, exp_r.wait_ms,
                                exp_r.front_notify, exp_r.last, exp_r.pending,
                                res_ch.status, res_ch.handle, res_ch.wait_ms,
                                res_ch.front_notify, res_ch.last, res_ch.pending);
                    end
                end
            end
            res_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        if (hang_count >= HANG_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    function automatic t_timer_cmd make_cmd(t_cmd op, logic [63:0] now_v, logic [3:0] id,
                                            logic [63:0] per, logic rep, logic fnow);
        t_timer_cmd c;
        c.command = op;
        c.now_ms = now_v;
        c.timer_id = id;
        c.period_ms = per;
        c.repeat_req = rep;
        c.restart_now = fnow;
        return c;
    endfunction

    // Track which slots surely have had their period written, so a reset with an
    // unchanged period never reads a slot that was never written. Until the
    // first cancel or collect after an add, the adds fill slots in index order.
    logic gen_written [NT];
    int   gen_adds = 0;
    logic gen_frozen = 1'b0;

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    task automatic push_cmd(t_timer_cmd c);
        if (c.command == CMD_ADD && !gen_frozen && gen_adds < NT) begin
            gen_written[gen_adds] = 1'b1;
            gen_adds++;
        end
        if ((c.command == CMD_CANCEL || c.command == CMD_COLLECT) && gen_adds > 0)
            gen_frozen = 1'b1;
        if (c.command == CMD_RESET && !c.restart_now && !gen_written[c.timer_id])
            c.restart_now = 1'b1;
        cmd_queue.insert(cmd_queue.size(), c);
    endtask

    task automatic random_cmd();
        t_timer_cmd c;
        int pick;
        pick = $urandom_range(99);
        clock_ms += $urandom_range(60);
        c = make_cmd(CMD_ADD, clock_ms, 4'($urandom_range(NT - 1)),
                     64'($urandom_range(200)), 1'($urandom), 1'($urandom));
        if (pick < 5) c.now_ms = rand64();
        if (pick < 8) c.period_ms = rand64();
        if (pick < 30) c.command = CMD_ADD;
        else if (pick < 40) c.command = CMD_CANCEL;
        else if (pick < 48) c.command = CMD_REFRESH;
        else if (pick < 58) c.command = CMD_RESET;
        else if (pick < 72) c.command = CMD_NEXT_WAIT;
        else if (pick < 97) c.command = CMD_COLLECT;
        else c.command = t_cmd'(3'($urandom_range(6, 7)));
        if (c.command == CMD_COLLECT && $urandom_range(29) == 0) begin
            // Step the clock back past an hour; everything expires.
            clock_ms += 64'd4000000;
            push_cmd(make_cmd(CMD_COLLECT, clock_ms, 4'd0, 64'd0, 1'b0, 1'b0));
            c.now_ms = clock_ms - 64'd3700000;
        end
        push_cmd(c);
    endtask

    task automatic drain();
        while (cmd_queue.size() > 0 || cmd_ch.valid || expected_results.size() > 0)
            @(posedge i_clk);
        repeat (60) @(posedge i_clk);
    endtask

    initial begin
        cmd_ch.valid = 1'b0;
        cmd_ch.command = '0;
        cmd_ch.now_ms = '0;
        cmd_ch.timer_id = '0;
        cmd_ch.period_ms = '0;
        cmd_ch.repeat_req = 1'b0;
        cmd_ch.restart_now = 1'b0;
        res_ch.ready = 1'b0;
        for (int i = 0; i < NT; i++) begin
            sh_active[i] = 1'b0;
            sh_repeat[i] = 1'b0;
            sh_period[i] = '0;
            sh_deadline[i] = '0;
            gen_written[i] = 1'b0;
        end
        sh_notice = 1'b0;
        sh_prev_time = '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: empty table, fill to full, extremes, inactive slots, clock back.
        push_cmd(make_cmd(CMD_NEXT_WAIT, 64'd0, 4'd0, 64'd0, 1'b0, 1'b0));
        push_cmd(make_cmd(CMD_COLLECT, 64'd5, 4'd0, 64'd0, 1'b0, 1'b0));
        push_cmd(make_cmd(CMD_CANCEL, 64'd5, 4'hF, 64'd0, 1'b0, 1'b0));
        push_cmd(make_cmd(CMD_REFRESH, 64'd5, 4'd3, 64'd0, 1'b0, 1'b0));
        push_cmd(make_cmd(CMD_ADD, '1, 4'd0, '1, 1'b1, 1'b0));
        push_cmd(make_cmd(CMD_ADD, 64'd100, 4'd0, 64'd50, 1'b0, 1'b0));
        push_cmd(make_cmd(CMD_ADD, 64'd100, 4'd0, 64'd50, 1'b1, 1'b0));
        for (int i = 3; i < NT; i++)
            push_cmd(make_cmd(CMD_ADD, 64'd100, 4'd0, 64'(1000 + i), 1'(i), 1'b0));
        push_cmd(make_cmd(CMD_ADD, 64'd100, 4'd0, 64'd1, 1'b0, 1'b0));
        push_cmd(make_cmd(CMD_NEXT_WAIT, 64'd120, 4'd0, 64'd0, 1'b0, 1'b0));
        push_cmd(make_cmd(CMD_RESET, 64'd120, 4'd1, 64'd10, 1'b0, 1'b0));
        push_cmd(make_cmd(CMD_RESET, 64'd120, 4'd2, 64'd50, 1'b0, 1'b0));
        push_cmd(make_cmd(CMD_RESET, 64'd120, 4'd4, 64'd5, 1'b1, 1'b1));
        push_cmd(make_cmd(CMD_COLLECT, 64'd160, 4'd0, 64'd0, 1'b0, 1'b0));
        push_cmd(make_cmd(CMD_COLLECT, 64'd5000000, 4'd0, 64'd0, 1'b0, 1'b0));
        push_cmd(make_cmd(CMD_COLLECT, 64'd10, 4'd0, 64'd0, 1'b0, 1'b0));
        push_cmd(make_cmd(t_cmd'(3'd7), 64'd10, 4'd0, 64'd0, 1'b0, 1'b0));
        clock_ms = 64'd10000000;

        for (int ph = 0; ph < 3; ph++) begin
            if (ph == 1) begin
                send_idle_pct = 58;
                recv_idle_pct = 21;
            end else if (ph == 2) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            for (int n = 0; n < 130; n++) random_cmd();
            drain();
        end

        if (mismatches == 0 && expected_results.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end
endmodule

FILE: sim.f
rtl/stq_pkg.sv
rtl/stq_if.sv
rtl/stq_alu.sv
rtl/sorted_timer_queue_top.sv
verif/sorted_timer_queue_top_tb.sv
